@@ design/rsfs_pkg.sv @@
// Shared types and constants for the RGB LED strobe/fade sequencer.
// No dependencies; used by rsfs_ctrl, rsfs_dp and the top level.
`default_nettype none

package rsfs_pkg;

    // Default fade step in milliseconds
    localparam int STEP_MS_DEFAULT = 20;

    localparam int COLOR_W = 24;
    localparam int CHAN_W  = 8;
    localparam int TIME_W  = 16;
    localparam int REP_W   = 8;
    localparam int EL_W    = 17;
    localparam int CFG_IDX_W = 3;

    // Divider produces one quotient bit per cycle
    localparam int QUO_W = CHAN_W;
    localparam int DIV_CNT_W = $clog2(QUO_W);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(QUO_W - 1);

    // Channel slots inside a packed color
    localparam logic [1:0] CH_RED   = 2'd2;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd0;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_STOP  = 2'd2
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COLOR_ON        = 3'd0,
        REG_COLOR_OFF       = 3'd1,
        REG_STROBE_ON_TIME  = 3'd2,
        REG_STROBE_OFF_TIME = 3'd3,
        REG_FADE_IN_TIME    = 3'd4,
        REG_FADE_OUT_TIME   = 3'd5,
        REG_HOLD_TIME       = 3'd6,
        REG_REPEAT_LIMIT    = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_FADE_IN  = 2'd1,
        PH_HOLD     = 2'd2,
        PH_FADE_OUT = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MUL,
        ST_ADD,
        ST_DIV,
        ST_COMMIT
    } ctrl_state_t;

    // Controller -> datapath commands
    typedef struct packed {
        logic       capture;
        logic       mul;
        logic       add;
        logic       div;
        logic       last;
        logic       commit;
        logic [1:0] chan;
    } dp_cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic need_blend;
    } dp_sts_t;

endpackage

`default_nettype wire

@@ design/rgb_led_strobe_fade_sequencer_unit.sv @@
// A beat that needs no color blend goes from acceptance through evaluation
// to commit; a fade ramp step adds three multiply/divide passes after
// evaluation (one per channel, 1 quotient bit per cycle) before commit.
// Beats are taken only in idle, after the previous beat has committed.
// A new beat is taken while the previous result waits on out_ready.
// Reset (rst_n, async, low): effect idle, LED zero; result regs not reset.
`default_nettype none

module rgb_led_strobe_fade_sequencer_unit #(
    parameter int STEP_MS = rsfs_pkg::STEP_MS_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration write channel
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [rsfs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rsfs_pkg::COLOR_W-1:0]    cfg_data,
    // input channel
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [1:0]                      command,
    input  wire logic                            effect_select,
    input  wire logic [rsfs_pkg::TIME_W-1:0]     start_delay,
    // output channel
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [rsfs_pkg::CHAN_W-1:0]          red,
    output logic [rsfs_pkg::CHAN_W-1:0]          green,
    output logic [rsfs_pkg::CHAN_W-1:0]          blue,
    output logic                                 active,
    output logic                                 finished
);
    import rsfs_pkg::*;

    dp_cmd_t dp_cmd;
    dp_sts_t dp_sts;

    // Registers accept a write every cycle
    assign cfg_ready = 1'b1;

    rsfs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (dp_cmd),
        .sts       (dp_sts)
    );

    rsfs_dp #(
        .STEP_MS (STEP_MS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .command       (command),
        .effect_select (effect_select),
        .start_delay   (start_delay),
        .cmd           (dp_cmd),
        .sts           (dp_sts),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .active        (active),
        .finished      (finished)
    );

endmodule

`default_nettype wire

@@ design/rsfs_dp.sv @@
// Datapath: config registers, effect state, blend divider and result registers.
// Depends on rsfs_pkg; sequenced by rsfs_ctrl.
`default_nettype none

module rsfs_dp #(
    parameter int STEP_MS = rsfs_pkg::STEP_MS_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_valid,
    input  wire logic [rsfs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [rsfs_pkg::COLOR_W-1:0]       cfg_data,
    input  wire logic [1:0]                         command,
    input  wire logic                               effect_select,
    input  wire logic [rsfs_pkg::TIME_W-1:0]        start_delay,
    input  rsfs_pkg::dp_cmd_t                       cmd,
    output rsfs_pkg::dp_sts_t                       sts,
    output logic [rsfs_pkg::CHAN_W-1:0]             red,
    output logic [rsfs_pkg::CHAN_W-1:0]             green,
    output logic [rsfs_pkg::CHAN_W-1:0]             blue,
    output logic                                    active,
    output logic                                    finished
);
    import rsfs_pkg::*;

    // Configuration
    logic [COLOR_W-1:0] color_on_reg, color_off_reg;
    logic [TIME_W-1:0]  strobe_on_reg, strobe_off_reg;
    logic [TIME_W-1:0]  fade_in_reg, fade_out_reg, hold_reg;
    logic [REP_W-1:0]   repeat_limit_reg;

    // Effect state
    logic               running_reg, running_next;
    logic               kind_reg, kind_next;
    logic               lit_reg, lit_next;
    phase_t             phase_reg, phase_next;
    logic [EL_W-1:0]    el_reg, el_next;
    logic [REP_W-1:0]   rep_reg, rep_next;
    logic [TIME_W-1:0]  wait_reg, wait_next;
    logic [COLOR_W-1:0] led_reg, led_next;
    logic               done_next;

    // Captured input beat
    logic [1:0]         cmd_in_reg;
    logic               sel_reg;
    logic [TIME_W-1:0]  delay_reg;

    // Divider
    logic [COLOR_W-1:0] num_reg, dvs_reg, blend_reg, blend_next;
    logic [QUO_W-2:0]   quo_reg;

    // Result registers
    logic [CHAN_W-1:0]  red_reg, green_reg, blue_reg;
    logic               active_reg, finished_reg;

    function automatic logic [TIME_W-1:0] sched(input logic [TIME_W-1:0] ms);
        return (ms == '0) ? TIME_W'(1) : ms;
    endfunction

    function automatic logic [CHAN_W-1:0] chan_of(input logic [COLOR_W-1:0] c,
                                                  input logic [1:0] idx);
        logic [CHAN_W-1:0] v;
        case (idx)
            CH_RED:   v = c[23:16];
            CH_GREEN: v = c[15:8];
            default:  v = c[7:0];
        endcase
        return v;
    endfunction

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_on_reg     <= '0;
            color_off_reg    <= '0;
            strobe_on_reg    <= '0;
            strobe_off_reg   <= '0;
            fade_in_reg      <= '0;
            fade_out_reg     <= '0;
            hold_reg         <= '0;
            repeat_limit_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_COLOR_ON:        color_on_reg     <= cfg_data;
                REG_COLOR_OFF:       color_off_reg    <= cfg_data;
                REG_STROBE_ON_TIME:  strobe_on_reg    <= cfg_data[TIME_W-1:0];
                REG_STROBE_OFF_TIME: strobe_off_reg   <= cfg_data[TIME_W-1:0];
                REG_FADE_IN_TIME:    fade_in_reg      <= cfg_data[TIME_W-1:0];
                REG_FADE_OUT_TIME:   fade_out_reg     <= cfg_data[TIME_W-1:0];
                REG_HOLD_TIME:       hold_reg         <= cfg_data[TIME_W-1:0];
                REG_REPEAT_LIMIT:    repeat_limit_reg <= cfg_data[REP_W-1:0];
                default: ;
            endcase
        end
    end

    // Input capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_in_reg <= command;
            sel_reg    <= effect_select;
            delay_reg  <= start_delay;
        end
    end

    // Blend operands: fade in goes on -> off, fade out goes off -> on
    logic               fwd;
    logic [COLOR_W-1:0] from_c, to_c;
    logic [TIME_W-1:0]  tot, diff;
    logic [CHAN_W-1:0]  a_ch, b_ch;
    logic               bypass;
    logic [COLOR_W-1:0] prod_a, prod_b;
    logic               ge;
    logic [QUO_W-1:0]   quo_full;
    logic [CHAN_W-1:0]  lerp_val;

    assign fwd      = (phase_reg == PH_FADE_IN);
    assign from_c   = fwd ? color_on_reg  : color_off_reg;
    assign to_c     = fwd ? color_off_reg : color_on_reg;
    assign tot      = fwd ? fade_in_reg   : fade_out_reg;
    assign diff     = tot - el_reg[TIME_W-1:0];
    assign a_ch     = chan_of(from_c, cmd.chan);
    assign b_ch     = chan_of(to_c, cmd.chan);
    assign bypass   = (tot == '0) || (el_reg >= {1'b0, tot});
    assign prod_a   = {16'd0, a_ch} * {8'd0, diff};
    assign prod_b   = {16'd0, b_ch} * {8'd0, el_reg[TIME_W-1:0]};
    assign ge       = (num_reg >= dvs_reg);
    assign quo_full = {quo_reg, ge};
    assign lerp_val = bypass ? b_ch : quo_full;

    always_comb
    begin
        blend_next = blend_reg;
        case (cmd.chan)
            CH_RED:   blend_next[23:16] = lerp_val;
            CH_GREEN: blend_next[15:8]  = lerp_val;
            default:  blend_next[7:0]   = lerp_val;
        endcase
    end

    // Multiply, accumulate, then restoring divide one bit per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            num_reg <= prod_a;
            dvs_reg <= {1'b0, tot, 7'd0};
        end
        else if (cmd.add)
        begin
            num_reg <= num_reg + prod_b;
        end
        else if (cmd.div)
        begin
            if (ge)
                num_reg <= num_reg - dvs_reg;
            dvs_reg <= dvs_reg >> 1;
            quo_reg <= quo_full[QUO_W-2:0];
            if (cmd.last)
                blend_reg <= blend_next;
        end
    end

    // Step evaluation
    logic            stop_now, cyc, halt_cmd, cont, blend_use;
    logic [EL_W-1:0] el_inc;

    assign stop_now = (repeat_limit_reg != '0) && (rep_reg <= REP_W'(1));
    assign el_inc   = el_reg + EL_W'(STEP_MS);

    always_comb
    begin
        running_next = running_reg;
        kind_next    = kind_reg;
        lit_next     = lit_reg;
        phase_next   = phase_reg;
        el_next      = el_reg;
        rep_next     = rep_reg;
        wait_next    = wait_reg;
        led_next     = led_reg;
        done_next    = 1'b0;
        cyc          = 1'b0;
        halt_cmd     = 1'b0;
        cont         = 1'b1;
        blend_use    = 1'b0;

        case (cmd_in_reg)
            CMD_TICK:
            begin
                if (running_reg)
                begin
                    if (wait_reg > TIME_W'(1))
                        wait_next = wait_reg - TIME_W'(1);
                    else if (!kind_reg)
                    begin
                        // strobe
                        if (!lit_reg)
                        begin
                            led_next  = color_on_reg;
                            lit_next  = 1'b1;
                            wait_next = sched(strobe_on_reg);
                        end
                        else
                        begin
                            led_next = color_off_reg;
                            lit_next = 1'b0;
                            cyc      = 1'b1;
                            if (!stop_now)
                                wait_next = sched(strobe_off_reg);
                        end
                    end
                    else
                    begin
                        // fade in
                        if (phase_reg == PH_FADE_IN)
                        begin
                            if ((fade_in_reg != '0) && (el_inc < {1'b0, fade_in_reg}))
                            begin
                                led_next  = blend_reg;
                                el_next   = el_inc;
                                wait_next = TIME_W'(STEP_MS);
                                blend_use = 1'b1;
                                cont      = 1'b0;
                            end
                            else
                            begin
                                led_next   = color_off_reg;
                                phase_next = PH_HOLD;
                                el_next    = '0;
                                if (hold_reg != '0)
                                begin
                                    wait_next = hold_reg;
                                    cont      = 1'b0;
                                end
                            end
                        end
                        // end of hold, or end of fade in when hold time is zero
                        if (cont && ((phase_reg == PH_FADE_IN) || (phase_reg == PH_HOLD)))
                        begin
                            if (fade_out_reg != '0)
                            begin
                                phase_next = PH_FADE_OUT;
                                el_next    = '0;
                                wait_next  = TIME_W'(1);
                            end
                            else
                            begin
                                cyc = 1'b1;
                                if (!stop_now)
                                begin
                                    led_next   = color_on_reg;
                                    phase_next = PH_FADE_IN;
                                    el_next    = '0;
                                    wait_next  = TIME_W'(1);
                                end
                            end
                        end
                        // fade out
                        if (phase_reg == PH_FADE_OUT)
                        begin
                            if ((fade_out_reg != '0) && (el_inc < {1'b0, fade_out_reg}))
                            begin
                                led_next  = blend_reg;
                                el_next   = el_inc;
                                wait_next = TIME_W'(STEP_MS);
                                blend_use = 1'b1;
                            end
                            else
                            begin
                                led_next = color_on_reg;
                                cyc      = 1'b1;
                                if (!stop_now)
                                begin
                                    phase_next = PH_FADE_IN;
                                    el_next    = '0;
                                    wait_next  = TIME_W'(1);
                                end
                            end
                        end
                    end
                end
            end
            CMD_START:
            begin
                running_next = 1'b1;
                kind_next    = sel_reg;
                lit_next     = 1'b0;
                rep_next     = repeat_limit_reg;
                el_next      = '0;
                if (sel_reg)
                begin
                    phase_next = PH_FADE_IN;
                    led_next   = color_on_reg;
                end
                else
                    phase_next = PH_IDLE;
                wait_next = sched(delay_reg);
            end
            CMD_STOP:
            begin
                halt_cmd = 1'b1;
            end
            default: ;
        endcase

        // End of one effect cycle: count repeats
        if (cyc && (repeat_limit_reg != '0))
            rep_next = (rep_reg == '0) ? '0 : rep_reg - REP_W'(1);

        if (halt_cmd || (cyc && stop_now))
        begin
            running_next = 1'b0;
            kind_next    = 1'b0;
            lit_next     = 1'b0;
            phase_next   = PH_IDLE;
            el_next      = '0;
            rep_next     = '0;
            wait_next    = '0;
            done_next    = cyc && stop_now;
        end
    end

    assign sts.need_blend = blend_use;

    // State commit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            kind_reg    <= 1'b0;
            lit_reg     <= 1'b0;
            phase_reg   <= PH_IDLE;
            el_reg      <= '0;
            rep_reg     <= '0;
            wait_reg    <= '0;
            led_reg     <= '0;
        end
        else if (cmd.commit)
        begin
            running_reg <= running_next;
            kind_reg    <= kind_next;
            lit_reg     <= lit_next;
            phase_reg   <= phase_next;
            el_reg      <= el_next;
            rep_reg     <= rep_next;
            wait_reg    <= wait_next;
            led_reg     <= led_next;
        end
    end

    // Result beat
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            red_reg      <= led_next[23:16];
            green_reg    <= led_next[15:8];
            blue_reg     <= led_next[7:0];
            active_reg   <= running_next;
            finished_reg <= done_next;
        end
    end

    assign red      = red_reg;
    assign green    = green_reg;
    assign blue     = blue_reg;
    assign active   = active_reg;
    assign finished = finished_reg;

endmodule

`default_nettype wire

@@ design/rsfs_ctrl.sv @@
// Controller FSM: accepts input beats, runs the per-channel blend divide,
// commits the step and holds the output valid. Depends on rsfs_pkg.
`default_nettype none

module rsfs_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    output rsfs_pkg::dp_cmd_t  cmd,
    input  rsfs_pkg::dp_sts_t  sts
);
    import rsfs_pkg::*;

    ctrl_state_t          state_reg, state_next;
    logic [1:0]           chan_reg, chan_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 commit_ok;

    // Output register is free or being drained this cycle
    assign commit_ok = !out_valid_reg || out_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        chan_next  = chan_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (sts.need_blend)
                begin
                    state_next = ST_MUL;
                    chan_next  = CH_RED;
                end
                else
                    state_next = ST_COMMIT;
            end
            ST_MUL:
            begin
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                state_next = ST_DIV;
                cnt_next   = '0;
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_LAST)
                begin
                    if (chan_reg == CH_BLUE)
                        state_next = ST_COMMIT;
                    else
                    begin
                        chan_next  = chan_reg - 2'd1;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_COMMIT:
            begin
                if (commit_ok)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath commands
    always_comb
    begin
        cmd         = '0;
        cmd.chan    = chan_reg;
        cmd.capture = (state_reg == ST_IDLE) && in_valid;
        cmd.mul     = (state_reg == ST_MUL);
        cmd.add     = (state_reg == ST_ADD);
        cmd.div     = (state_reg == ST_DIV);
        cmd.last    = (state_reg == ST_DIV) && (cnt_reg == DIV_LAST);
        cmd.commit  = (state_reg == ST_COMMIT) && commit_ok;
        in_ready    = (state_reg == ST_IDLE);
        out_valid   = out_valid_reg;
    end

    always_comb
    begin
        if ((state_reg == ST_COMMIT) && commit_ok)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            chan_reg      <= CH_RED;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chan_reg      <= chan_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Checks
    a_accept_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == ST_EVAL)
        else $error("accepted beat did not move to evaluation");

    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || out_ready))
        else $error("commit would overwrite a pending result");

    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV && cnt_reg == DIV_LAST |=>
            state_reg == ST_MUL || state_reg == ST_COMMIT)
        else $error("divide did not end after the last quotient bit");

    a_valid_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_COMMIT)
        else $error("result valid raised outside commit");

    a_chan_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> chan_reg != 2'd3)
        else $error("channel index out of range");

endmodule

`default_nettype wire
